>>> rtl/dirty_row_run_to_rects_core_assert.svh
// Assertion macros shared by the dirty row run coalescing RTL.
// Clock and active-low reset are passed in by the user of each macro.
`ifndef DIRTY_ROW_RUN_TO_RECTS_CORE_ASSERT_SVH
`define DIRTY_ROW_RUN_TO_RECTS_CORE_ASSERT_SVH

// Same-cycle implication.
`define DRRR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("drrr assertion failed");

// Next-cycle implication.
`define DRRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("drrr assertion failed");

`endif

>>> rtl/drrr_pkg.sv
// Package for the dirty row run coalescing core: field widths, register
// indexes and the run descriptor passed from the merge stage. No dependencies.
`timescale 1ns / 1ps
package drrr_pkg;

	localparam int DIRTY_W  = 20;  // dirty flags carried by one row
	localparam int ROW_W    = 5;
	localparam int COL_W    = 5;   // column index and run length
	localparam int CFG_W    = 8;
	localparam int CFG_IDX_W = 1;
	localparam int X_W      = 13;
	localparam int Y_W      = 12;
	localparam int H_W      = 7;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_HEIGHT = 1'd1;

	typedef struct packed {
		logic [COL_W-1:0] start;
		logic [COL_W-1:0] len;
		logic             last;
	} run_t;

endpackage

>>> rtl/drrr_lane.sv
// One column lane: flags whether a dirty run opens or closes at this column.
// Depends on nothing; neighbour flags are tied low at the row edges.
`timescale 1ns / 1ps
module drrr_lane (
	input  logic dirty,
	input  logic left_dirty,
	input  logic right_dirty,
	output logic run_open,
	output logic run_close
);

	assign run_open  = dirty & ~left_dirty;
	assign run_close = dirty & ~right_dirty;

endmodule

>>> rtl/drrr_merge.sv
// Merge stage: holds the open/close masks of one row and hands out its runs,
// lowest column first, one per transaction. Depends on drrr_pkg and dirty_row_run_to_rects_core_assert.svh.
`timescale 1ns / 1ps
`include "dirty_row_run_to_rects_core_assert.svh"
module drrr_merge
	import drrr_pkg::*;
#(
	parameter int NCOL = 20
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  logic [NCOL-1:0] open_mask,
	input  logic [NCOL-1:0] close_mask,
	output logic            ready,
	output logic            run_valid,
	input  logic            take,
	output run_t            run
);

	logic            valid_s1;
	logic [NCOL-1:0] open_s1;
	logic [NCOL-1:0] close_s1;
	logic [NCOL-1:0] open_nxt;
	logic [NCOL-1:0] close_nxt;
	logic [COL_W-1:0] open_idx;
	logic [COL_W-1:0] close_idx;

	// Lowest set bit of each mask; the first close always belongs to the first open.
	always_comb begin
		open_idx  = '0;
		close_idx = '0;
		for (int i = NCOL - 1; i >= 0; i--) begin
			if (open_s1[i]) begin
				open_idx = COL_W'(i);
			end
			if (close_s1[i]) begin
				close_idx = COL_W'(i);
			end
		end
	end

	assign open_nxt  = open_s1 & (open_s1 - 1'b1);
	assign close_nxt = close_s1 & (close_s1 - 1'b1);

	assign run.start = open_idx;
	assign run.len   = close_idx - open_idx + 1'b1;
	assign run.last  = (open_nxt == '0);

	assign run_valid = valid_s1;
	assign ready     = ~valid_s1 | (take & run.last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take & run.last) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			open_s1  <= open_mask;
			close_s1 <= close_mask;
		end else if (take) begin
			open_s1  <= open_nxt;
			close_s1 <= close_nxt;
		end
	end

	`DRRR_ASSERT_IMPLIES(a_masks_pair, clk, arst_n, valid_s1,
		$countones(open_s1) == $countones(close_s1))
	`DRRR_ASSERT_IMPLIES(a_held_row_nonempty, clk, arst_n, valid_s1, open_s1 != '0)
	`DRRR_ASSERT_NEXT(a_last_run_frees, clk, arst_n, take & run.last & ~load, !valid_s1)

endmodule

>>> rtl/dirty_row_run_to_rects_core.sv
// Top level of the dirty row run coalescing core: input stream, register
// port, column lanes, merge stage and output register. Depends on drrr_pkg, drrr_lane and drrr_merge.
`timescale 1ns / 1ps
// Use:
//   s_axis carries one strip row per transaction: row index and one dirty
//   flag per block column. m_axis returns one update rectangle per maximal
//   run of dirty columns, left to right, tlast on the row's final rectangle.
//   The cfg channel writes block_width (index 0) and block_height (index 1);
//   it is always ready and is to be written only while the core is idle.
// Flow:
//   The first rectangle of a row is registered in the merge stage, then in
//   the output register once that register is free. Rectangles leave at
//   one per cycle while m_axis_tready is high, as the merge stage hands out
//   one run per take; a row holds the merge stage until all its runs (at
//   most 10 for 20 columns) have moved on, and the next row is taken in the
//   cycle its predecessor's last run moves to the output register. Rows with
//   no dirty column or off the screen are accepted and give nothing.
// Reset:
//   arst_n clears all valid flags at once and loads both block sizes to 40.
// Stall:
//   While m_axis_tready is low the output register holds its rectangle, the
//   merge stage holds its row, and s_axis_tready stays low once both are full.
module dirty_row_run_to_rects_core
	import drrr_pkg::*;
#(
	parameter int COLUMNS = 20,
	parameter int ROWS    = 25
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// row_index [4:0], dirty_bits [24:5], zero fill [31:25]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// rect_x [12:0], rect_y [24:13], rect_w [37:25], rect_h [44:38], zero fill [47:45]
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	output logic                  m_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]      cfg_data
);

	// Columns past the dirty field or past the screen edge never take part.
	localparam int NCOL = (COLUMNS < DIRTY_W) ? COLUMNS : DIRTY_W;

	logic [CFG_W-1:0]   block_width_q;
	logic [CFG_W-1:0]   block_height_q;

	logic [ROW_W-1:0]   row;
	logic [DIRTY_W-1:0] dirty;
	logic [NCOL-1:0]    open_mask;
	logic [NCOL-1:0]    close_mask;
	logic               row_on_screen;
	logic               in_fire;
	logic               load;
	logic               merge_ready;
	logic               run_valid;
	logic               take;
	run_t               run;
	logic [X_W-1:0]     row_prod;
	logic [X_W-1:0]     x_prod;
	logic [X_W-1:0]     w_prod;

	logic [Y_W-1:0]     y_s1;
	logic [H_W-1:0]     h_s1;

	logic               valid_s2;
	logic [X_W-1:0]     x_s2;
	logic [Y_W-1:0]     y_s2;
	logic [X_W-1:0]     w_s2;
	logic [H_W-1:0]     h_s2;
	logic               last_s2;

	// Register port: always ready, write on the transaction.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_width_q  <= CFG_W'(40);
			block_height_q <= CFG_W'(40);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLOCK_WIDTH:  block_width_q  <= cfg_data;
				REG_BLOCK_HEIGHT: block_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Unpack the row transaction.
	assign row   = s_axis_tdata[ROW_W-1:0];
	assign dirty = s_axis_tdata[ROW_W +: DIRTY_W];

	// One lane per live column, each looking at its two neighbours.
	for (genvar c = 0; c < NCOL; c++) begin : g_lane
		logic left_d;
		logic right_d;
		if (c == 0) begin : g_left_edge
			assign left_d = 1'b0;
		end else begin : g_left_inner
			assign left_d = dirty[c-1];
		end
		if (c == NCOL - 1) begin : g_right_edge
			assign right_d = 1'b0;
		end else begin : g_right_inner
			assign right_d = dirty[c+1];
		end
		drrr_lane u_lane (
			.dirty       (dirty[c]),
			.left_dirty  (left_d),
			.right_dirty (right_d),
			.run_open    (open_mask[c]),
			.run_close   (close_mask[c])
		);
	end

	// Off-screen and clean rows are accepted and dropped here.
	assign row_on_screen = ({{(32-ROW_W){1'b0}}, row} < 32'(ROWS));
	assign s_axis_tready = merge_ready;
	assign in_fire       = s_axis_tvalid & s_axis_tready;
	assign load          = in_fire & row_on_screen & (|open_mask);

	// Strip geometry is fixed for the whole row; compute it once on entry.
	assign row_prod = {{(X_W-CFG_W){1'b0}}, block_height_q} * {{(X_W-ROW_W){1'b0}}, row};

	always_ff @(posedge clk) begin
		if (load) begin
			y_s1 <= row_prod[Y_W:1];
			h_s1 <= block_height_q[CFG_W-1:1];
		end
	end

	drrr_merge #(
		.NCOL (NCOL)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.open_mask  (open_mask),
		.close_mask (close_mask),
		.ready      (merge_ready),
		.run_valid  (run_valid),
		.take       (take),
		.run        (run)
	);

	// Advance a run into the output register whenever that register frees up.
	assign take   = run_valid & (~valid_s2 | m_axis_tready);
	assign x_prod = {{(X_W-CFG_W){1'b0}}, block_width_q} * {{(X_W-COL_W){1'b0}}, run.start};
	assign w_prod = {{(X_W-CFG_W){1'b0}}, block_width_q} * {{(X_W-COL_W){1'b0}}, run.len};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s2    <= x_prod;
			y_s2    <= y_s1;
			w_s2    <= w_prod;
			h_s2    <= h_s1;
			last_s2 <= run.last;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tlast  = last_s2;
	assign m_axis_tdata  = {{(OUT_DATA_W-2*X_W-Y_W-H_W){1'b0}}, h_s2, w_s2, y_s2, x_s2};

endmodule
